[rtl/sjf_pkg.sv]
`timescale 1ns / 1ps
package sjf_pkg;

  localparam int unsigned FieldWidth = 16;

  typedef logic [FieldWidth-1:0] field_t;

  typedef struct packed {
    logic   valid;
    field_t id;
    field_t length;
    field_t run;
    field_t waited;
  } entry_t;

  // Broadcast from the top level to every cell for one tick.
  typedef struct packed {
    logic   ins_en;
    logic   done;
    entry_t new_entry;
  } ctrl_t;

  function automatic field_t sat_inc(input field_t v);
    return (v == '1) ? v : field_t'(v + 1'b1);
  endfunction

endpackage

[rtl/sjf_cell.sv]
`timescale 1ns / 1ps
module sjf_cell #(
  parameter bit IS_HEAD = 1'b0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  sjf_pkg::ctrl_t  ctrl,
  input  sjf_pkg::entry_t left_entry,
  input  logic           left_after,
  input  sjf_pkg::entry_t right_entry,
  input  logic           right_after,
  output sjf_pkg::entry_t entry,
  output logic           after
);
  import sjf_pkg::*;

  entry_t ins_self;
  entry_t ins_right;
  entry_t entry_next;

  // This slot lies at or beyond the insertion point; the head only when empty.
  always_comb begin
    if (IS_HEAD) begin
      after = !entry.valid;
    end else begin
      after = !entry.valid || (entry.length > ctrl.new_entry.length);
    end
  end

  // Slot contents after the arrival is placed, here and one to the right.
  always_comb begin
    ins_self  = entry;
    ins_right = right_entry;
    if (ctrl.ins_en) begin
      if (after) begin
        ins_self = left_after ? left_entry : ctrl.new_entry;
      end
      if (right_after) begin
        ins_right = after ? entry : ctrl.new_entry;
      end
    end
  end

  // Tick: the head runs, the others wait; on completion shift left.
  always_comb begin
    if (ctrl.done) begin
      entry_next        = ins_right;
      entry_next.waited = sat_inc(ins_right.waited);
    end else if (IS_HEAD) begin
      entry_next     = ins_self;
      entry_next.run = sat_inc(ins_self.run);
    end else begin
      entry_next        = ins_self;
      entry_next.waited = sat_inc(ins_self.waited);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (en) begin
      entry <= entry_next;
    end
  end

endmodule

[rtl/shortest_job_first_scheduler_top.sv]
`timescale 1ns / 1ps
// Non-preemptive shortest-job-first scheduler built as a row of QUEUE_DEPTH
// sorted cells. Each accepted transaction (start high, busy low) is one
// scheduler tick: every cell compares the arriving length against its own,
// makes room or shifts, and updates its run or wait count in the same cycle,
// so a new tick can be started in every cycle. The result of a tick appears
// on the result ports in the cycle after it is accepted, for one cycle,
// marked by result_valid; it must be taken then. busy is high only while
// reset is held.
module shortest_job_first_scheduler_top #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                arrive_valid,
  input  sjf_pkg::field_t     job_len,
  output logic                result_valid,
  output logic                running_valid,
  output sjf_pkg::field_t     running_id,
  output logic                done_res,
  output sjf_pkg::field_t     done_id,
  output sjf_pkg::field_t     done_run,
  output sjf_pkg::field_t     done_wait,
  output logic                dropped,
  output logic                queue_empty
);
  import sjf_pkg::*;

  entry_t cell_entry [QUEUE_DEPTH];
  logic   cell_after [QUEUE_DEPTH];
  ctrl_t  ctrl;
  field_t next_id;
  logic   accept;
  logic   full;
  entry_t head;
  field_t head_run;

  assign busy   = rst;
  assign accept = start && !busy;
  assign full   = cell_entry[QUEUE_DEPTH-1].valid;

  always_comb begin
    ctrl.ins_en           = arrive_valid && !full;
    ctrl.new_entry.valid  = 1'b1;
    ctrl.new_entry.id     = next_id;
    ctrl.new_entry.length = job_len;
    ctrl.new_entry.run    = '0;
    ctrl.new_entry.waited = '0;
    // An arrival into an empty queue becomes the head at once.
    head     = (ctrl.ins_en && !cell_entry[0].valid) ? ctrl.new_entry : cell_entry[0];
    head_run = sat_inc(head.run);
    ctrl.done = head.valid && (head.length <= head_run);
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_e;
    logic   left_a;
    entry_t right_e;
    logic   right_a;
    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_a = 1'b0;
    end else begin : g_mid_l
      assign left_e = cell_entry[i-1];
      assign left_a = cell_after[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_e = '0;
      assign right_a = 1'b1;
    end else begin : g_mid_r
      assign right_e = cell_entry[i+1];
      assign right_a = cell_after[i+1];
    end
    sjf_cell #(
      .IS_HEAD (i == 0)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .en          (accept),
      .ctrl        (ctrl),
      .left_entry  (left_e),
      .left_after  (left_a),
      .right_entry (right_e),
      .right_after (right_a),
      .entry       (cell_entry[i]),
      .after       (cell_after[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_id      <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= accept;
      if (accept && ctrl.ins_en) begin
        next_id <= field_t'(next_id + 1'b1);
      end
    end
  end

  // Queue is empty after the tick when nothing is left once the head leaves.
  logic second_valid;
  always_comb begin
    if (QUEUE_DEPTH > 1) begin
      second_valid = (cell_entry[0].valid && cell_entry[1 % QUEUE_DEPTH].valid)
                  || (cell_entry[0].valid && ctrl.ins_en);
    end else begin
      second_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      running_valid <= head.valid;
      running_id    <= head.valid ? head.id : '0;
      done_res      <= ctrl.done;
      done_id       <= ctrl.done ? head.id : '0;
      done_run      <= ctrl.done ? head_run : '0;
      done_wait     <= ctrl.done ? head.waited : '0;
      dropped       <= arrive_valid && full;
      queue_empty   <= !head.valid || (ctrl.done && !second_valid);
    end
  end

endmodule

[rtl/sjf_checker.sv]
`timescale 1ns / 1ps
module sjf_checker (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            result_valid,
  input logic            running_valid,
  input logic            done_res,
  input sjf_pkg::field_t done_run,
  input logic            dropped,
  input logic            queue_empty
);
  import sjf_pkg::*;

  // Every accepted transaction yields exactly one result in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> result_valid)
    else $error("accepted transaction gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !result_valid)
    else $error("result without a transaction");

  a_done_ran: assert property (@(posedge clk) disable iff (rst)
    (result_valid && done_res) |-> (running_valid && done_run != '0))
    else $error("finished job did not run");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (result_valid && dropped) |-> (!queue_empty && running_valid))
    else $error("drop reported with room in the queue");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !running_valid) |-> queue_empty)
    else $error("queue not empty although nothing ran");

endmodule

bind shortest_job_first_scheduler_top sjf_checker u_sjf_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .result_valid  (result_valid),
  .running_valid (running_valid),
  .done_res      (done_res),
  .done_run      (done_run),
  .dropped       (dropped),
  .queue_empty   (queue_empty)
);

[bench/tb_shortest_job_first_scheduler_top.sv]
`timescale 1ns / 1ps
module tb_shortest_job_first_scheduler_top;
  import sjf_pkg::*;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned CycleLimit = 100_000;
  localparam int unsigned RandomBursts = 32;
  localparam int unsigned BurstItems = 50;

  typedef struct packed {
    logic   running_valid;
    field_t running_id;
    logic   done_res;
    field_t done_id;
    field_t done_run;
    field_t done_wait;
    logic   dropped;
    logic   queue_empty;
  } tick_t;

  class sjf_scoreboard;
    entry_t      ready_q[QueueDepth];
    int unsigned used;
    field_t      next_id;
    tick_t       expected_ticks[$];
    int unsigned errors;

    function new();
      used = 0;
      next_id = '0;
      errors = 0;
      for (int i = 0; i < QueueDepth; i++) ready_q[i] = '0;
    endfunction

    function field_t bump(input field_t v);
      return (v == 16'hFFFF) ? v : field_t'(v + 16'd1);
    endfunction

    // Work out what one accepted tick reports and advance the queue.
    function void note_tick(input logic arrive, input field_t len);
      tick_t       r;
      int unsigned pos;
      int unsigned i;
      logic        found;
      r = '0;
      if (arrive) begin
        if (used >= QueueDepth) begin
          r.dropped = 1'b1;
        end else begin
          pos = used;
          found = 1'b0;
          // never ahead of the running head, after equal lengths
          for (i = 1; i < used; i++) begin
            if (!found && ready_q[i].length > len) begin
              pos = i;
              found = 1'b1;
            end
          end
          for (i = used; i > pos; i--) ready_q[i] = ready_q[i-1];
          ready_q[pos] = '{valid: 1'b1, id: next_id, length: len, run: '0, waited: '0};
          next_id = field_t'(next_id + 16'd1);
          used++;
        end
      end
      if (used > 0) begin
        r.running_valid = 1'b1;
        r.running_id = ready_q[0].id;
        ready_q[0].run = bump(ready_q[0].run);
        for (i = 1; i < used; i++) ready_q[i].waited = bump(ready_q[i].waited);
        if (ready_q[0].length <= ready_q[0].run) begin
          r.done_res = 1'b1;
          r.done_id = ready_q[0].id;
          r.done_run = ready_q[0].run;
          r.done_wait = ready_q[0].waited;
          for (i = 1; i < used; i++) ready_q[i-1] = ready_q[i];
          ready_q[used-1] = '0;
          used--;
        end
      end
      r.queue_empty = (used == 0);
      expected_ticks.push_back(r);
    endfunction

    function void check_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_tick(input tick_t got);
      tick_t exp_t;
      if (expected_ticks.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
        return;
      end
      exp_t = expected_ticks.pop_front();
      check_field("running_valid", 16'(exp_t.running_valid), 16'(got.running_valid));
      check_field("running_id", exp_t.running_id, got.running_id);
      check_field("done_res", 16'(exp_t.done_res), 16'(got.done_res));
      check_field("done_id", exp_t.done_id, got.done_id);
      check_field("done_run", exp_t.done_run, got.done_run);
      check_field("done_wait", exp_t.done_wait, got.done_wait);
      check_field("dropped", 16'(exp_t.dropped), 16'(got.dropped));
      check_field("queue_empty", 16'(exp_t.queue_empty), 16'(got.queue_empty));
    endfunction
  endclass

  logic   clk;
  logic   rst;
  logic   start;
  logic   busy;
  logic   arrive_valid;
  field_t job_len;
  logic   result_valid;
  logic   running_valid;
  field_t running_id;
  logic   done_res;
  field_t done_id;
  field_t done_run;
  field_t done_wait;
  logic   dropped;
  logic   queue_empty;

  sjf_scoreboard sched;
  int unsigned   cycles;

  shortest_job_first_scheduler_top #(
    .QUEUE_DEPTH(QueueDepth)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .arrive_valid (arrive_valid),
    .job_len      (job_len),
    .result_valid (result_valid),
    .running_valid(running_valid),
    .running_id   (running_id),
    .done_res     (done_res),
    .done_id      (done_id),
    .done_run     (done_run),
    .done_wait    (done_wait),
    .dropped      (dropped),
    .queue_empty  (queue_empty)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("shortest_job_first_scheduler_top: mismatch");
      $finish;
    end
  end

  // Take each result in the cycle it is shown; it cannot be held off.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      sched.check_tick('{running_valid, running_id, done_res, done_id, done_run,
                         done_wait, dropped, queue_empty});
    end
  end

  task automatic send_tick(input logic arrive, input field_t len, input int unsigned gap);
    start <= 1'b1;
    arrive_valid <= arrive;
    job_len <= len;
    do @(posedge clk); while (busy);
    sched.note_tick(arrive, len);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic idle_until_empty();
    while (sched.used != 0) send_tick(1'b0, field_t'($urandom), 0);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sched.expected_ticks.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned arrive_pct;
    int unsigned max_gap;
    int unsigned pick;
    logic        arr;
    field_t      len;

    sched = new();
    rst <= 1'b1;
    start <= 1'b0;
    arrive_valid <= 1'b0;
    job_len <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // idle with empty queue, zero length, shortest legal run
    send_tick(1'b0, 16'hFFFF, 0);
    send_tick(1'b1, 16'h0000, 0);
    send_tick(1'b1, 16'h0001, 0);
    // shorter arrivals queue behind the running head, equal lengths keep order
    send_tick(1'b1, 16'd3, 0);
    send_tick(1'b1, 16'd2, 0);
    send_tick(1'b1, 16'd2, 0);
    send_tick(1'b1, 16'd1, 0);
    idle_until_empty();

    // fill the queue behind a long head, then drop arrivals while full
    send_tick(1'b1, 16'd60, 0);
    repeat (QueueDepth - 1) send_tick(1'b1, field_t'($urandom_range(8, 40)), 0);
    send_tick(1'b1, 16'h5555, 0);
    send_tick(1'b1, 16'hAAAA, 0);
    send_tick(1'b1, 16'h0000, 0);
    idle_until_empty();
    wait_drained();

    for (int b = 0; b < RandomBursts; b++) begin
      pick = $urandom_range(0, 2);
      arrive_pct = (pick == 0) ? 30 : (pick == 1) ? 60 : 95;
      max_gap = ($urandom_range(0, 3) == 0) ? 0 : 4;
      for (int k = 0; k < BurstItems; k++) begin
        arr = ($urandom_range(0, 99) < arrive_pct);
        pick = $urandom_range(0, 99);
        if (!arr) len = field_t'($urandom);
        else if (pick < 80) len = field_t'($urandom_range(0, 15));
        else if (pick < 97) len = field_t'($urandom_range(16, 255));
        else len = field_t'($urandom_range(256, 4095));
        send_tick(arr, len, $urandom_range(0, max_gap));
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (sched.errors == 0) begin
      $display("shortest_job_first_scheduler_top: match");
    end else begin
      $display("shortest_job_first_scheduler_top: mismatch");
    end
    $finish;
  end

endmodule
